FILE: hw/rtl/rvb_pkg.sv
// Shared constants, register and state codes, types and arithmetic helpers of the reverb.
package rvb_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int MAX_DELAY = 4096;
  localparam int LINE_AW   = $clog2(MAX_DELAY);
  localparam int NUM_LINES = 4;
  localparam int LINE_SW   = $clog2(NUM_LINES);
  localparam int MEM_AW    = LINE_SW + LINE_AW;
  localparam int LEN_W     = 12;
  localparam int GAIN_W    = 16;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 16;
  localparam int MUL_AW    = 17;
  localparam int PROD_W    = 33;
  localparam int WIDE_W    = 36;
  localparam int IN_DW     = 16;
  localparam int OUT_DW    = 48;

  localparam logic [MUL_AW-1:0] MIX_FULL  = 17'd32768;
  localparam logic [15:0]       MIX_LIMIT = 16'd32768;
  localparam int                Q15_ROUND = 16384;

  // register indexes of the configuration port
  localparam logic [CFG_AW-1:0] REG_AP_GAIN   = 4'd0;
  localparam logic [CFG_AW-1:0] REG_CL_GAIN   = 4'd1;
  localparam logic [CFG_AW-1:0] REG_CR_GAIN   = 4'd2;
  localparam logic [CFG_AW-1:0] REG_WET_MIX   = 4'd3;
  localparam logic [CFG_AW-1:0] REG_AP0_LEN   = 4'd4;
  localparam logic [CFG_AW-1:0] REG_AP1_LEN   = 4'd5;
  localparam logic [CFG_AW-1:0] REG_CL_LEN    = 4'd6;
  localparam logic [CFG_AW-1:0] REG_CR_LEN    = 4'd7;

  // delay line slots in the shared memory
  localparam logic [LINE_SW-1:0] LINE_AP0 = 2'd0;
  localparam logic [LINE_SW-1:0] LINE_AP1 = 2'd1;
  localparam logic [LINE_SW-1:0] LINE_CL  = 2'd2;
  localparam logic [LINE_SW-1:0] LINE_CR  = 2'd3;

  // sequencer states
  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE = 4'd0;
  localparam logic [ST_W-1:0] ST_P0   = 4'd1;
  localparam logic [ST_W-1:0] ST_P1   = 4'd2;
  localparam logic [ST_W-1:0] ST_P2   = 4'd3;
  localparam logic [ST_W-1:0] ST_P3   = 4'd4;
  localparam logic [ST_W-1:0] ST_P4   = 4'd5;
  localparam logic [ST_W-1:0] ST_P5   = 4'd6;
  localparam logic [ST_W-1:0] ST_P6   = 4'd7;
  localparam logic [ST_W-1:0] ST_P7   = 4'd8;
  localparam logic [ST_W-1:0] ST_P8   = 4'd9;
  localparam logic [ST_W-1:0] ST_P9   = 4'd10;
  localparam logic [ST_W-1:0] ST_DONE = 4'd11;
  localparam logic [ST_W-1:0] ST_CLR  = 4'd12;

  typedef struct packed {
    logic [ST_W-1:0] state;
    logic            start;
    logic            ld_out;
  } rvb_ctl_t;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'((1 <<< (SAMPLE_W - 1)) - 1);
    lo = -hi - WIDE_W'(1);
    if (v > hi) begin
      return SAMPLE_W'(hi);
    end else if (v < lo) begin
      return SAMPLE_W'(lo);
    end
    return SAMPLE_W'(v);
  endfunction

  // floor((p + 2^14) / 2^15)
  function automatic logic signed [17:0] q15(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] t;
    t = (PROD_W+1)'(p) + (PROD_W+1)'(Q15_ROUND);
    return $signed(t[PROD_W-1:15]);
  endfunction

endpackage

FILE: hw/rtl/rvb_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
module rvb_ram #(
  parameter int DATA_W = 16,
  parameter int ADDR_W = 14
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/rvb_ctrl.sv
// Sequencer: clearing pass, step order, write pointer, memory addresses and handshakes.
module rvb_ctrl
  import rvb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  logic [LEN_W-1:0]  ap0_len,
  input  logic [LEN_W-1:0]  ap1_len,
  input  logic [LEN_W-1:0]  cl_len,
  input  logic [LEN_W-1:0]  cr_len,
  output logic              mem_we,
  output logic [MEM_AW-1:0] mem_waddr,
  output logic [MEM_AW-1:0] mem_raddr,
  output rvb_ctl_t          ctl
);

  logic [ST_W-1:0]    state_r, state_nxt;
  logic [LINE_AW-1:0] wp_r, wp_nxt;
  logic [MEM_AW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic               start;
  logic               ld_out;
  logic [LEN_W-1:0]   rd_len;
  logic [LINE_AW-1:0] rd_eff;
  logic [LINE_SW-1:0] rd_line;
  logic [LINE_SW-1:0] wr_line;
  logic               wr_step;

  assign in_tready  = (state_r == ST_IDLE);
  assign start      = in_tvalid && in_tready;
  assign ld_out     = (state_r == ST_DONE) && (!out_vld_r || out_tready);
  assign out_tvalid = out_vld_r;

  assign ctl.state  = state_r;
  assign ctl.start  = start;
  assign ctl.ld_out = ld_out;

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLR: begin
        clr_cnt_nxt = clr_cnt_r + MEM_AW'(1);
        if (&clr_cnt_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: if (start) state_nxt = ST_P0;
      ST_P0:   state_nxt = ST_P1;
      ST_P1:   state_nxt = ST_P2;
      ST_P2:   state_nxt = ST_P3;
      ST_P3:   state_nxt = ST_P4;
      ST_P4:   state_nxt = ST_P5;
      ST_P5:   state_nxt = ST_P6;
      ST_P6:   state_nxt = ST_P7;
      ST_P7:   state_nxt = ST_P8;
      ST_P8:   state_nxt = ST_P9;
      ST_P9:   state_nxt = ST_DONE;
      ST_DONE: if (ld_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (ld_out) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  assign wp_nxt = ld_out ? wp_r + LINE_AW'(1) : wp_r;

  // read side: one line per step, P0..P3
  always_comb begin
    case (state_r)
      ST_P0: begin
        rd_line = LINE_AP0;
        rd_len  = ap0_len;
      end
      ST_P1: begin
        rd_line = LINE_AP1;
        rd_len  = ap1_len;
      end
      ST_P2: begin
        rd_line = LINE_CL;
        rd_len  = cl_len;
      end
      ST_P3: begin
        rd_line = LINE_CR;
        rd_len  = cr_len;
      end
      default: begin
        rd_line = LINE_AP0;
        rd_len  = ap0_len;
      end
    endcase
  end

  // zero length acts as one; 12-bit lengths never reach the line depth
  assign rd_eff    = (rd_len == '0) ? LINE_AW'(1) : LINE_AW'(rd_len);
  assign mem_raddr = {rd_line, wp_r - rd_eff};

  always_comb begin
    wr_step = 1'b1;
    case (state_r)
      ST_P2:   wr_line = LINE_AP0;
      ST_P5:   wr_line = LINE_AP1;
      ST_P7:   wr_line = LINE_CL;
      ST_P8:   wr_line = LINE_CR;
      default: begin
        wr_line = LINE_AP0;
        wr_step = 1'b0;
      end
    endcase
  end

  assign mem_we    = wr_step || (state_r == ST_CLR);
  assign mem_waddr = (state_r == ST_CLR) ? clr_cnt_r : {wr_line, wp_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      wp_r      <= '0;
      clr_cnt_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wp_r      <= wp_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

FILE: hw/rtl/rvb_dp.sv
// Datapath: shared multiplier, allpass and comb arithmetic, line outputs and output register.
module rvb_dp
  import rvb_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  rvb_ctl_t                   ctl,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic signed [GAIN_W-1:0]   ap_gain,
  input  logic signed [GAIN_W-1:0]   cl_gain,
  input  logic signed [GAIN_W-1:0]   cr_gain,
  input  logic [15:0]                wet_mix,
  input  logic [SAMPLE_W-1:0]        mem_rdata,
  output logic [SAMPLE_W-1:0]        mem_wdata,
  output logic signed [SAMPLE_W-1:0] left_out,
  output logic signed [SAMPLE_W-1:0] right_out,
  output logic signed [SAMPLE_W-1:0] mono_out
);

  logic signed [SAMPLE_W-1:0] last0_r, last1_r, last2_r, last3_r;
  logic signed [SAMPLE_W-1:0] nl0_r, nl1_r, w2_r, w3_r;
  logic signed [SAMPLE_W-1:0] x_r, v0_r, y0_r, v1_r, y1_r;
  logic signed [17:0]         ta_r, tb_r;
  logic signed [PROD_W-1:0]   prod_r, drx_r;
  logic signed [SAMPLE_W-1:0] left_r, right_r;
  logic signed [SAMPLE_W-1:0] left_o_r, right_o_r, mono_o_r;

  logic signed [MUL_AW-1:0]   mul_a;
  logic signed [SAMPLE_W-1:0] mul_b;
  logic signed [MUL_AW-1:0]   wet_s, dry_s;
  logic [MUL_AW-1:0]          wet_u;
  logic signed [17:0]         q;
  logic signed [PROD_W+1:0]   mix_sum;
  logic signed [19:0]         mix_q;
  logic signed [SAMPLE_W-1:0] mix_sat;
  logic signed [SAMPLE_W-1:0] c2, c3;
  logic signed [SAMPLE_W:0]   lr_sum;

  // mix above full acts as all wet
  assign wet_u = (wet_mix > MIX_LIMIT) ? MIX_FULL : {1'b0, wet_mix};
  assign wet_s = $signed(wet_u);
  assign dry_s = $signed(MIX_FULL - wet_u);

  always_comb begin
    case (ctl.state)
      ST_P0: begin
        mul_a = MUL_AW'(ap_gain);
        mul_b = last0_r;
      end
      ST_P1: begin
        mul_a = MUL_AW'(ap_gain);
        mul_b = last1_r;
      end
      ST_P2: begin
        mul_a = MUL_AW'(ap_gain);
        mul_b = v0_r;
      end
      ST_P3: begin
        mul_a = MUL_AW'(cl_gain);
        mul_b = last2_r;
      end
      ST_P4: begin
        mul_a = MUL_AW'(cr_gain);
        mul_b = last3_r;
      end
      ST_P5: begin
        mul_a = MUL_AW'(ap_gain);
        mul_b = v1_r;
      end
      ST_P6: begin
        mul_a = dry_s;
        mul_b = x_r;
      end
      ST_P7: begin
        mul_a = wet_s;
        mul_b = w2_r;
      end
      ST_P8: begin
        mul_a = wet_s;
        mul_b = w3_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign q       = q15(prod_r);
  assign c2      = sat16(WIDE_W'(y1_r) + WIDE_W'(ta_r));
  assign c3      = sat16(WIDE_W'(y1_r) + WIDE_W'(tb_r));
  assign mix_sum = (PROD_W+2)'(prod_r) + (PROD_W+2)'(drx_r) + (PROD_W+2)'(Q15_ROUND);
  assign mix_q   = $signed(mix_sum[PROD_W+1:15]);
  assign mix_sat = sat16(WIDE_W'(mix_q));
  assign lr_sum  = (SAMPLE_W+1)'(left_r) + (SAMPLE_W+1)'(right_r);

  always_comb begin
    case (ctl.state)
      ST_P2:   mem_wdata = v0_r;
      ST_P5:   mem_wdata = v1_r;
      ST_P7:   mem_wdata = c2;
      ST_P8:   mem_wdata = c3;
      default: mem_wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (ctl.start) begin
      x_r <= sample_in;
    end
    case (ctl.state)
      ST_P1: begin
        v0_r  <= sat16(WIDE_W'(x_r) + WIDE_W'(q));
        nl0_r <= $signed(mem_rdata);
      end
      ST_P2: begin
        ta_r  <= q;
        nl1_r <= $signed(mem_rdata);
      end
      ST_P3: begin
        y0_r <= sat16(WIDE_W'(last0_r) - WIDE_W'(q));
        w2_r <= $signed(mem_rdata);
      end
      ST_P4: begin
        v1_r <= sat16(WIDE_W'(y0_r) + WIDE_W'(ta_r));
        ta_r <= q;
        w3_r <= $signed(mem_rdata);
      end
      ST_P5: tb_r <= q;
      ST_P6: y1_r <= sat16(WIDE_W'(last1_r) - WIDE_W'(q));
      ST_P7: drx_r <= prod_r;
      ST_P8: left_r <= mix_sat;
      ST_P9: right_r <= mix_sat;
      default: ;
    endcase
    if (ctl.ld_out) begin
      left_o_r  <= left_r;
      right_o_r <= right_r;
      mono_o_r  <= lr_sum[SAMPLE_W:1];
    end
  end

  // line outputs are committed once the item is done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last0_r <= '0;
      last1_r <= '0;
      last2_r <= '0;
      last3_r <= '0;
    end else if (ctl.ld_out) begin
      last0_r <= nl0_r;
      last1_r <= nl1_r;
      last2_r <= w2_r;
      last3_r <= w3_r;
    end
  end

  assign left_out  = left_o_r;
  assign right_out = right_o_r;
  assign mono_out  = mono_o_r;

endmodule

FILE: hw/rtl/stereo_allpass_comb_reverb_top.sv
// Top level of the mono-in, stereo-out allpass and comb reverb.
//
// Input channel in_*: one signed 16-bit mono sample per item.
// Output channel out_*: left, right and mono (floor of their average) per item.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr at the clock edge;
// indexes 8 and above are ignored. Write only while the block is idle.
// All four delay lines share one 16K x 16 memory (4 lines of 4096 words) with one
// write and one registered read port; every item makes four reads and four writes.
// After an input item is taken the sequencer steps P0..P9 and loads the output register
// in DONE. One item at a time: a new item is taken only in IDLE, since the sequencer steps
// through the single multiplier (nine products) and the single memory port pair.
// Reset: synchronous, active low. Afterwards a clearing pass zeroes the memory,
// one word per cycle over all 16384 words, with in_tready low; config writes still work.
// Stall: the result sits in an output register; a new item is accepted and worked
// on meanwhile, and the sequencer waits at its last step until the slot frees.
module stereo_allpass_comb_reverb_top
  import rvb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // [15:0] sample_in
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // [15:0] left_out, [31:16] right_out, [47:32] mono_out
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  logic [GAIN_W-1:0] ap_gain_r, cl_gain_r, cr_gain_r;
  logic [15:0]       wet_mix_r;
  logic [LEN_W-1:0]  ap0_len_r, ap1_len_r, cl_len_r, cr_len_r;

  rvb_ctl_t                   ctl;
  logic                       mem_we;
  logic [MEM_AW-1:0]          mem_waddr, mem_raddr;
  logic [SAMPLE_W-1:0]        mem_wdata, mem_rdata;
  logic signed [SAMPLE_W-1:0] left_out, right_out, mono_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ap_gain_r <= 16'd22938;
      cl_gain_r <= 16'd20316;
      cr_gain_r <= 16'hA51F;
      wet_mix_r <= 16'd16384;
      ap0_len_r <= 12'd658;
      ap1_len_r <= 12'd2053;
      cl_len_r  <= 12'd4000;
      cr_len_r  <= 12'd3321;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_AP_GAIN: ap_gain_r <= cfg_wdata;
        REG_CL_GAIN: cl_gain_r <= cfg_wdata;
        REG_CR_GAIN: cr_gain_r <= cfg_wdata;
        REG_WET_MIX: wet_mix_r <= cfg_wdata;
        REG_AP0_LEN: ap0_len_r <= cfg_wdata[LEN_W-1:0];
        REG_AP1_LEN: ap1_len_r <= cfg_wdata[LEN_W-1:0];
        REG_CL_LEN:  cl_len_r  <= cfg_wdata[LEN_W-1:0];
        REG_CR_LEN:  cr_len_r  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  rvb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ap0_len    (ap0_len_r),
    .ap1_len    (ap1_len_r),
    .cl_len     (cl_len_r),
    .cr_len     (cr_len_r),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_raddr  (mem_raddr),
    .ctl        (ctl)
  );

  rvb_ram #(
    .DATA_W (SAMPLE_W),
    .ADDR_W (MEM_AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rvb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sample_in ($signed(in_tdata[SAMPLE_W-1:0])),
    .ap_gain   ($signed(ap_gain_r)),
    .cl_gain   ($signed(cl_gain_r)),
    .cr_gain   ($signed(cr_gain_r)),
    .wet_mix   (wet_mix_r),
    .mem_rdata (mem_rdata),
    .mem_wdata (mem_wdata),
    .left_out  (left_out),
    .right_out (right_out),
    .mono_out  (mono_out)
  );

  assign out_tdata = {mono_out, right_out, left_out};

endmodule

FILE: hw/rtl/rvb_chk.sv
// Port-level checker for the reverb top level, bound to it.
module rvb_chk
  import rvb_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [IN_DW-1:0]  in_tdata,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic              cfg_we,
  input logic [CFG_AW-1:0] cfg_addr,
  input logic [CFG_DW-1:0] cfg_wdata
);

  logic signed [SAMPLE_W:0] lr_sum;

  assign lr_sum = (SAMPLE_W+1)'($signed(out_tdata[15:0]))
                + (SAMPLE_W+1)'($signed(out_tdata[31:16]));

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output item changed while stalled");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again while an item is in work");

  // mono is the floor of the mean of left and right
  a_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:32] == lr_sum[SAMPLE_W:1])
    else $error("mono output is not the average of left and right");

  // after reset: clearing pass, no result
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("ready or valid high right after reset");

endmodule

bind stereo_allpass_comb_reverb_top rvb_chk u_rvb_chk (.*);

FILE: tb/sv/reverb_checker.sv
// Checker for the reverb: tracks register writes, predicts each output item and compares.
`timescale 1ns / 1ps

module reverb_checker
  import rvb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // [15:0] sample_in
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_DW-1:0] out_tdata,  // [15:0] left_out, [31:16] right_out, [47:32] mono_out
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output int                fail_count,
  output int                pending
);

  localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam int     MAX_PRINTS = 40;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mono;
    logic signed [SAMPLE_W-1:0] right;
    logic signed [SAMPLE_W-1:0] left;
  } stereo_mix_t;

  logic signed [SAMPLE_W-1:0] line_mem [NUM_LINES][MAX_DELAY];
  logic signed [SAMPLE_W-1:0] line_last [NUM_LINES];
  logic [LEN_W-1:0]           line_len [NUM_LINES];
  logic [LINE_AW-1:0]         wr_ptr;
  logic [GAIN_W-1:0]          ap_gain;
  logic [GAIN_W-1:0]          cl_gain;
  logic [GAIN_W-1:0]          cr_gain;
  logic [GAIN_W-1:0]          wet_reg;

  stereo_mix_t mix_q[$];
  int          errors = 0;

  function automatic longint clip16(longint v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    if (v < SAMPLE_MIN) return SAMPLE_MIN;
    return v;
  endfunction

  // rounded Q1.15 product, floor after adding half
  function automatic longint mul_q15(longint g, longint v);
    return (g * v + Q15_ROUND) >>> 15;
  endfunction

  // read the delayed tap, then store the new sample at the write pointer
  function automatic longint tap_line(int ln, longint v);
    int                 n;
    logic [LINE_AW-1:0] rd;
    n = line_len[ln];
    if (n == 0) n = 1;
    if (n >= MAX_DELAY) n = MAX_DELAY - 1;
    rd = wr_ptr - LINE_AW'(n);
    tap_line = line_mem[ln][rd];
    line_mem[ln][wr_ptr] = v[SAMPLE_W-1:0];
  endfunction

  function automatic stereo_mix_t predict_mix(logic signed [SAMPLE_W-1:0] x_in);
    longint      x, ag, gl, gr, wet, dry, a, b;
    longint      v0, y0, v1, y1, c2, c3, w2, w3, l, r, mv;
    stereo_mix_t m;
    x   = x_in;
    ag  = $signed(ap_gain);
    gl  = $signed(cl_gain);
    gr  = $signed(cr_gain);
    wet = (wet_reg > MIX_LIMIT) ? 32768 : longint'(wet_reg);
    dry = 32768 - wet;

    a  = line_last[LINE_AP0];
    v0 = clip16(x + mul_q15(ag, a));
    line_last[LINE_AP0] = SAMPLE_W'(tap_line(LINE_AP0, v0));
    y0 = clip16(a - mul_q15(ag, v0));

    b  = line_last[LINE_AP1];
    v1 = clip16(y0 + mul_q15(ag, b));
    line_last[LINE_AP1] = SAMPLE_W'(tap_line(LINE_AP1, v1));
    y1 = clip16(b - mul_q15(ag, v1));

    c2 = clip16(y1 + mul_q15(gl, line_last[LINE_CL]));
    c3 = clip16(y1 + mul_q15(gr, line_last[LINE_CR]));
    w2 = tap_line(LINE_CL, c2);
    w3 = tap_line(LINE_CR, c3);
    line_last[LINE_CL] = w2[SAMPLE_W-1:0];
    line_last[LINE_CR] = w3[SAMPLE_W-1:0];

    l  = clip16((wet * w2 + dry * x + Q15_ROUND) >>> 15);
    r  = clip16((wet * w3 + dry * x + Q15_ROUND) >>> 15);
    mv = (l + r) >>> 1;
    m.left  = l[SAMPLE_W-1:0];
    m.right = r[SAMPLE_W-1:0];
    m.mono  = mv[SAMPLE_W-1:0];
    wr_ptr  = wr_ptr + LINE_AW'(1);
    return m;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    stereo_mix_t got;
    stereo_mix_t want;
    if (!rst_n) begin
      ap_gain = 16'd22938;
      cl_gain = 16'd20316;
      cr_gain = 16'(-23265);
      wet_reg = 16'd16384;
      line_len[LINE_AP0] = 12'd658;
      line_len[LINE_AP1] = 12'd2053;
      line_len[LINE_CL]  = 12'd4000;
      line_len[LINE_CR]  = 12'd3321;
      for (int ln = 0; ln < NUM_LINES; ln++) begin
        line_last[ln] = '0;
        for (int i = 0; i < MAX_DELAY; i++) line_mem[ln][i] = '0;
      end
      wr_ptr = '0;
      mix_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_AP_GAIN: ap_gain = cfg_wdata;
          REG_CL_GAIN: cl_gain = cfg_wdata;
          REG_CR_GAIN: cr_gain = cfg_wdata;
          REG_WET_MIX: wet_reg = cfg_wdata;
          REG_AP0_LEN: line_len[LINE_AP0] = cfg_wdata[LEN_W-1:0];
          REG_AP1_LEN: line_len[LINE_AP1] = cfg_wdata[LEN_W-1:0];
          REG_CL_LEN:  line_len[LINE_CL]  = cfg_wdata[LEN_W-1:0];
          REG_CR_LEN:  line_len[LINE_CR]  = cfg_wdata[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        mix_q.push_back(predict_mix($signed(in_tdata[SAMPLE_W-1:0])));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (mix_q.size() == 0) begin
          report_mismatch("unexpected item, left", got.left, 0);
        end else begin
          want = mix_q.pop_front();
          if (got.left !== want.left)   report_mismatch("left_out", got.left, want.left);
          if (got.right !== want.right) report_mismatch("right_out", got.right, want.right);
          if (got.mono !== want.mono)   report_mismatch("mono_out", got.mono, want.mono);
        end
      end
    end
    pending    <= mix_q.size();
    fail_count <= errors;
  end

endmodule

FILE: tb/sv/tb_stereo_allpass_comb_reverb_top.sv
// Testbench top for the reverb: clock, reset, register setup, sample stimulus and verdict.
`timescale 1ns / 1ps

module tb_stereo_allpass_comb_reverb_top;
  import rvb_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 50;
  localparam int MAX_WAIT     = 18;
  localparam int SETTLE_TICKS = 16;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata  = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic              cfg_we    = 1'b0;
  logic [CFG_AW-1:0] cfg_addr  = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int cycles   = 0;
  bit in_idle  = 1'b0;
  bit out_idle = 1'b0;

  stereo_allpass_comb_reverb_top dut (.*);
  reverb_checker u_checker (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // output side: random stall per item when out_idle is set, tready never dropped and raised in one step
  initial begin : out_sink
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = out_idle ? $urandom_range(0, MAX_WAIT) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  task automatic push_sample(logic [IN_DW-1:0] s);
    int gap;
    gap = in_idle ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (in_tready !== 1'b1);
  endtask

  // wait until every predicted item has come out, then let the block settle
  task automatic drain_block();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CFG_DW-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return CFG_DW'($urandom);
    endcase
  endfunction

  // mostly short lines so the feedback shows up within a phase
  function automatic logic [CFG_DW-1:0] pick_len();
    case ($urandom_range(0, 7))
      0: return CFG_DW'($urandom_range(0, 15)) << LEN_W;
      1: return 16'd4095;
      2: return CFG_DW'($urandom);
      default: return CFG_DW'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [CFG_DW-1:0] pick_wet();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return MIX_LIMIT;
      2: return CFG_DW'($urandom_range(32769, 65535));
      default: return CFG_DW'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [IN_DW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return IN_DW'($urandom_range(0, 31)) - 16'd16;
      default: return IN_DW'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [IN_DW-1:0] full_scale [10];
    full_scale = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000,
                   16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h7FFF};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, no idling; waits out the memory clear
    foreach (full_scale[i]) push_sample(full_scale[i]);
    drain_block();

    // extreme gains, mix above full, zero and too-long lengths, ignored indexes
    write_reg(REG_AP_GAIN, 16'h7FFF);
    write_reg(REG_CL_GAIN, 16'h8000);
    write_reg(REG_CR_GAIN, 16'h7FFF);
    write_reg(REG_WET_MIX, 16'hFFFF);
    write_reg(REG_AP0_LEN, 16'h1000);
    write_reg(REG_AP1_LEN, 16'd1);
    write_reg(REG_CL_LEN, 16'd2);
    write_reg(REG_CR_LEN, 16'hFFFF);
    write_reg(CFG_AW'(8), 16'h1234);
    write_reg(CFG_AW'(15), 16'hFFFF);
    for (int i = 0; i < 10; i++) push_sample(i[0] ? 16'h8000 : 16'h7FFF);
    drain_block();

    // all dry, opposite gain extremes
    write_reg(REG_AP_GAIN, 16'h8000);
    write_reg(REG_CL_GAIN, 16'h7FFF);
    write_reg(REG_CR_GAIN, 16'h8000);
    write_reg(REG_WET_MIX, 16'd0);
    write_reg(REG_AP0_LEN, 16'd3);
    push_sample(16'h8000);
    push_sample(16'h7FFF);
    push_sample(16'h1234);
    push_sample(16'hFFFF);
    drain_block();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_reg(REG_AP_GAIN, pick_gain());
      write_reg(REG_CL_GAIN, pick_gain());
      write_reg(REG_CR_GAIN, pick_gain());
      write_reg(REG_WET_MIX, pick_wet());
      write_reg(REG_AP0_LEN, pick_len());
      write_reg(REG_AP1_LEN, pick_len());
      write_reg(REG_CL_LEN, pick_len());
      write_reg(REG_CR_LEN, pick_len());
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_AW'($urandom_range(8, 15)), CFG_DW'($urandom));
      in_idle  = $urandom_range(0, 3) != 0;
      out_idle = $urandom_range(0, 3) != 0;
      repeat (PHASE_ITEMS) push_sample(pick_sample());
      drain_block();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
